[hw/rtl/sbda_pkg.sv]
// Shared types and constants for the signed binary to decimal text converter.
// Depends on nothing; used by sbda_dabble and the top level.
`default_nettype none

package sbda_pkg;

    localparam int NIB_W = 4;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT
    } state_t;

endpackage

`default_nettype wire

[hw/rtl/sbda_dabble.sv]
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on sbda_pkg for the digit width.
`default_nettype none

module sbda_dabble #(
    parameter int VALUE_BITS = 32,
    parameter int DIGITS     = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [VALUE_BITS-1:0]                mag,
    output logic                                 done,
    output logic [DIGITS*sbda_pkg::NIB_W-1:0]    bcd
);

    localparam int BCD_W = DIGITS * sbda_pkg::NIB_W;
    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [VALUE_BITS-1:0] bin_reg;
    logic [VALUE_BITS-1:0] bin_next;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_next;
    logic [BCD_W-1:0]      adj;

    // Add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i*sbda_pkg::NIB_W +: sbda_pkg::NIB_W] >= 4'd5)
                adj[i*sbda_pkg::NIB_W +: sbda_pkg::NIB_W] =
                    bcd_reg[i*sbda_pkg::NIB_W +: sbda_pkg::NIB_W] + 4'd3;
            else
                adj[i*sbda_pkg::NIB_W +: sbda_pkg::NIB_W] =
                    bcd_reg[i*sbda_pkg::NIB_W +: sbda_pkg::NIB_W];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VALUE_BITS);
            bin_next  = mag;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
            bcd_next = {adj[BCD_W-2:0], bin_reg[VALUE_BITS-1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

`default_nettype wire

[hw/rtl/signed_binary_to_decimal_ascii_top.sv]
// Top level of the signed binary to decimal ASCII text converter.
// Depends on sbda_pkg and sbda_dabble.
`default_nettype none

// Takes one signed VALUE_BITS-wide word on the input channel and sends its
// decimal text on the output channel, one ASCII character per word: first a
// sign ('+' for zero and positive, '-' for negative), then the digits of the
// magnitude, most significant first, without leading zeros; last_char marks
// the final digit. The most negative value prints its true magnitude. Each
// value is loaded, shifted through the bit-serial shift-and-add-3 converter
// and handed off; then leading zeros are dropped one at a time (up to
// DIGITS-1), and one character is sent per cycle while the output side keeps
// up. Dropped zeros and sent digits always add up to DIGITS. One value is
// worked on at a time; in_ready is high only between values, and a finished
// character may still sit in the output register while the next value is
// taken.
module signed_binary_to_decimal_ascii_top #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   char_code,
    output logic                         last_char
);

    // Decimal digits that a magnitude up to 2^(VALUE_BITS-1) can need
    localparam int DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int BCD_W  = DIGITS * sbda_pkg::NIB_W;
    localparam int REM_W  = $clog2(DIGITS + 1);

    sbda_pkg::state_t      state_reg;
    sbda_pkg::state_t      state_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [REM_W-1:0]      rem_reg;
    logic [REM_W-1:0]      rem_next;
    logic [BCD_W-1:0]      digits_reg;
    logic [BCD_W-1:0]      digits_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [7:0]            char_code_reg;
    logic [7:0]            char_code_next;
    logic                  last_char_reg;
    logic                  last_char_next;

    logic                  in_accept;
    logic                  slot_free;
    logic [VALUE_BITS-1:0] value_u;
    logic [VALUE_BITS-1:0] mag;
    logic                  conv_start;
    logic                  conv_done;
    logic [BCD_W-1:0]      conv_bcd;
    logic [3:0]            top_digit;

    assign in_ready  = (state_reg == sbda_pkg::ST_IDLE);
    assign in_accept = in_valid && in_ready;
    // The output register can take a new word when empty or being drained
    assign slot_free = !out_valid_reg || out_ready;

    // Two's complement magnitude; the most negative value wraps to 2^(N-1)
    assign value_u    = value;
    assign mag        = value_u[VALUE_BITS-1] ? VALUE_BITS'(~value_u + 1'b1) : value_u;
    assign conv_start = in_accept;
    assign top_digit  = digits_reg[BCD_W-1 -: sbda_pkg::NIB_W];

    sbda_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS)
    ) u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .mag   (mag),
        .done  (conv_done),
        .bcd   (conv_bcd)
    );

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        digits_next    = digits_reg;
        char_code_next = char_code_reg;
        last_char_next = last_char_reg;
        // Drop the held word once the consumer takes it
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            sbda_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    neg_next   = value_u[VALUE_BITS-1];
                    state_next = sbda_pkg::ST_CONV;
                end
            end
            sbda_pkg::ST_CONV:
            begin
                // Hold until the converter has shifted in every bit
                if (conv_done)
                begin
                    digits_next = conv_bcd;
                    rem_next    = REM_W'(DIGITS);
                    state_next  = sbda_pkg::ST_SKIP;
                end
            end
            sbda_pkg::ST_SKIP:
            begin
                // Drop leading zeros, but always keep the final digit
                if (top_digit == 4'd0 && rem_reg != REM_W'(1))
                begin
                    digits_next = digits_reg << sbda_pkg::NIB_W;
                    rem_next    = rem_reg - 1'b1;
                end
                else
                begin
                    state_next = sbda_pkg::ST_SIGN;
                end
            end
            sbda_pkg::ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_code_next = neg_reg ? sbda_pkg::CH_MINUS : sbda_pkg::CH_PLUS;
                    last_char_next = 1'b0;
                    state_next     = sbda_pkg::ST_DIGIT;
                end
            end
            sbda_pkg::ST_DIGIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_code_next = sbda_pkg::CH_ZERO + {4'd0, top_digit};
                    last_char_next = (rem_reg == REM_W'(1));
                    digits_next    = digits_reg << sbda_pkg::NIB_W;
                    rem_next       = rem_reg - 1'b1;
                    if (rem_reg == REM_W'(1))
                        state_next = sbda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sbda_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbda_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg       <= neg_next;
        digits_reg    <= digits_next;
        char_code_reg <= char_code_next;
        last_char_reg <= last_char_next;
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_code_reg;
    assign last_char = last_char_reg;

    // A flagged final word is always a decimal digit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_char |-> char_code >= sbda_pkg::CH_ZERO &&
                                   char_code <= sbda_pkg::CH_NINE)
        else $error("last character is not a digit");

    // A sign word never ends the text
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (char_code == sbda_pkg::CH_PLUS || char_code == sbda_pkg::CH_MINUS)
        |-> !last_char)
        else $error("sign flagged as last character");

    // An accepted value starts conversion on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == sbda_pkg::ST_CONV)
        else $error("accepted value did not start conversion");

    // Digits are only skipped or sent while some remain
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sbda_pkg::ST_DIGIT || state_reg == sbda_pkg::ST_SKIP
        |-> rem_reg != '0)
        else $error("digit count ran out");

endmodule

`default_nettype wire
